FILE: rtl/cpba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_pkg: shared types and constants of the cyclic ID allocator
// Sizes of the ID bitmap, status and operation codes, and the bit search
// helper used by the controller.
// ----------------------------------------------------------------------------
package cpba_pkg;

  localparam int ID_SPACE   = 32768;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = ID_SPACE / WORD_BITS;
  localparam int ID_W       = 15;
  localparam int WADDR_W    = 9;
  localparam int OFF_W      = 6;
  localparam int LIMIT_W    = 16;
  localparam int COUNT_W    = 16;

  localparam logic [LIMIT_W-1:0] RESERVED_FLOOR = 16'd300;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'd32768;
  localparam logic [LIMIT_W-1:0] ID_SPACE_L     = 16'd32768;
  localparam logic [COUNT_W-1:0] COUNT_RESET    = 16'd32767;
  localparam logic [OFF_W-1:0]   WORD_MAX       = 6'd63;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NO_ID = 2'd1;
  localparam logic [1:0] STATUS_FREED = 2'd2;

  // Request kinds on the input channel.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [WADDR_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic               clearing;
    logic [COUNT_W-1:0] free_count;
  } ctrl_stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = OFF_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cyclic_pid_bitmap_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_pid_bitmap_allocator_top: next-fit ID allocator over a bitmap
// Hands out IDs cyclically from a 32768-bit bitmap and takes them back.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries requests: s_tuser is the kind (0 allocate, 1 free)
// and s_tdata the ID to release. Each request gives exactly one transaction on
// the master stream: m_tdata holds the allocated ID, m_tuser the status
// (0 allocated, 1 no free ID in range, 2 freed).
// A free or an allocation whose first candidate word has a clear bit reads
// the bitmap word, then checks it and writes it back. A contended scan
// reads each further 64-bit word in turn; the single bitmap read port sets
// this pace. Requests are handled one at a time.
// After reset the block sweeps the bitmap memory, one word per cycle, and
// holds s_tready low meanwhile; APB writes are taken throughout.
// The result sits in an output register, so the next request is accepted
// while it waits; a request that finishes before that result is taken waits
// in its check state until the output register frees up. Write id_limit (APB
// address 0) only while no request is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module cyclic_pid_bitmap_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [14:0] id_to_free, [15] zero
  input  wire logic [0:0]  s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [14:0] id_given, [15] zero
  output logic [1:0]       m_tuser,   // [1:0] status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [cpba_pkg::LIMIT_W-1:0]   id_limit;
  logic                           reg_hit;
  cpba_pkg::ram_req_t             ram_req;
  logic [cpba_pkg::WORD_BITS-1:0] ram_rdata;
  cpba_pkg::ctrl_stat_t           stat;
  logic [cpba_pkg::ID_W-1:0]      m_id;

  assign pready = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata = reg_hit ? {16'd0, id_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit <= cpba_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      id_limit <= pwdata[15:0];
    end
  end

  cpba_bitmap_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  cpba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .id_limit  (id_limit),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .s_func    (s_tuser[0]),
    .s_id      (s_tdata[14:0]),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_id      (m_id),
    .m_status  (m_tuser),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .stat      (stat)
  );

  assign m_tdata = {1'b0, m_id};

`ifndef SYNTHESIS
  // No request may enter while the bitmap is still being swept.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !s_tready)
    else $error("request accepted during bitmap clear");

  // The free count can never exceed the size of the ID space.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.free_count <= cpba_pkg::COUNT_W'(cpba_pkg::ID_SPACE))
    else $error("free count above ID space");

  // A successful allocation starts above the last ID, so it is never ID 0.
  a_alloc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == cpba_pkg::STATUS_OK) |-> (m_tdata != 16'd0))
    else $error("ID 0 handed out");

  // A new result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

FILE: rtl/cpba_bitmap_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_bitmap_ram: ID bitmap storage
// One write port and one read port with registered read data; the read data
// holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module cpba_bitmap_ram (
  input  wire logic                           clk,
  input  wire cpba_pkg::ram_req_t             req,
  output logic [cpba_pkg::WORD_BITS-1:0]      rdata
);

  logic [cpba_pkg::WORD_BITS-1:0] mem [cpba_pkg::NUM_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cpba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpba_ctrl: allocation and free sequencer
// Clears the bitmap after reset, then reads one bitmap word per request,
// scans word by word for a clear bit on contention and writes the word back.
// ----------------------------------------------------------------------------
module cpba_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [cpba_pkg::LIMIT_W-1:0]        id_limit,
  input  wire logic                                s_valid,
  output logic                                     s_ready,
  input  wire logic                                s_func,
  input  wire logic [cpba_pkg::ID_W-1:0]           s_id,
  output logic                                     m_valid,
  input  wire logic                                m_ready,
  output logic [cpba_pkg::ID_W-1:0]                m_id,
  output logic [1:0]                               m_status,
  output cpba_pkg::ram_req_t                       ram_req,
  input  wire logic [cpba_pkg::WORD_BITS-1:0]      ram_rdata,
  output cpba_pkg::ctrl_stat_t                     stat
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  logic [1:0]                      state, state_next;
  logic [1:0]                      op, op_next;
  logic [cpba_pkg::WADDR_W-1:0]    clr_addr, clr_addr_next;
  logic [cpba_pkg::WADDR_W-1:0]    cur_word, cur_word_next;
  logic [cpba_pkg::ID_W-1:0]       victim, victim_next;
  logic [cpba_pkg::ID_W-1:0]       lo, lo_next;
  logic [cpba_pkg::ID_W-1:0]       last, last_next;
  logic                            seg_b, seg_b_next;
  logic [cpba_pkg::ID_W-1:0]       seg_b_last, seg_b_last_next;
  logic [cpba_pkg::COUNT_W-1:0]    free_count, free_count_next;
  logic [cpba_pkg::ID_W-1:0]       last_id, last_id_next;
  logic                            m_valid_next;
  logic [cpba_pkg::ID_W-1:0]       m_id_next;
  logic [1:0]                      m_status_next;

  logic [cpba_pkg::LIMIT_W-1:0]    lim, start0, start;
  logic [cpba_pkg::LIMIT_W-1:0]    lim_m1, start_m1;
  logic                            out_free;
  logic [cpba_pkg::WORD_BITS-1:0]  mask_lo, mask_hi, cand;
  logic [cpba_pkg::OFF_W-1:0]      hit_off;
  logic [cpba_pkg::ID_W-1:0]       found;
  logic [cpba_pkg::WORD_BITS-1:0]  victim_bit, found_bit;

  always_comb begin
    lim = (id_limit > cpba_pkg::ID_SPACE_L) ? cpba_pkg::ID_SPACE_L : id_limit;
    start0 = {1'b0, last_id} + 16'd1;
    start = (start0 >= lim) ? cpba_pkg::RESERVED_FLOOR : start0;
    lim_m1 = lim - 16'd1;
    start_m1 = start - 16'd1;
    out_free = !m_valid || m_ready;

    // Only bits between the segment bounds may be taken in the current word.
    mask_lo = (cur_word == lo[14:6]) ? ({cpba_pkg::WORD_BITS{1'b1}} << lo[5:0])
                                     : {cpba_pkg::WORD_BITS{1'b1}};
    mask_hi = (cur_word == last[14:6])
              ? ({cpba_pkg::WORD_BITS{1'b1}} >> (cpba_pkg::WORD_MAX - last[5:0]))
              : {cpba_pkg::WORD_BITS{1'b1}};
    cand = ~ram_rdata & mask_lo & mask_hi;
    hit_off = cpba_pkg::lowest_set(cand);
    found = {cur_word, hit_off};
    found_bit = {{(cpba_pkg::WORD_BITS-1){1'b0}}, 1'b1} << hit_off;
    victim_bit = {{(cpba_pkg::WORD_BITS-1){1'b0}}, 1'b1} << victim[5:0];
  end

  always_comb begin
    state_next = state;
    op_next = op;
    clr_addr_next = clr_addr;
    cur_word_next = cur_word;
    victim_next = victim;
    lo_next = lo;
    last_next = last;
    seg_b_next = seg_b;
    seg_b_last_next = seg_b_last;
    free_count_next = free_count;
    last_id_next = last_id;
    m_valid_next = m_valid && !m_ready;
    m_id_next = m_id;
    m_status_next = m_status;
    ram_req = '0;
    s_ready = (state == ST_IDLE);

    unique case (state)
      ST_CLEAR: begin
        ram_req.we = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = (clr_addr == '0) ? {{(cpba_pkg::WORD_BITS-1){1'b0}}, 1'b1} : '0;
        clr_addr_next = clr_addr + 9'd1;
        if (clr_addr == 9'(cpba_pkg::NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid) begin
          state_next = ST_CHECK;
          if (s_func == cpba_pkg::FUNC_FREE) begin
            op_next = OP_FREE;
            victim_next = s_id;
            ram_req.re = 1'b1;
            ram_req.raddr = s_id[14:6];
          end else if (start >= lim || free_count == '0) begin
            op_next = OP_FAIL;
          end else begin
            op_next = OP_ALLOC;
            lo_next = start[14:0];
            last_next = lim_m1[14:0];
            cur_word_next = start[14:6];
            seg_b_next = cpba_pkg::RESERVED_FLOOR < start;
            seg_b_last_next = start_m1[14:0];
            ram_req.re = 1'b1;
            ram_req.raddr = start[14:6];
          end
        end
      end
      ST_CHECK: begin
        unique case (op)
          OP_FREE: begin
            if (out_free) begin
              if (ram_rdata[victim[5:0]]) begin
                ram_req.we = 1'b1;
                ram_req.waddr = victim[14:6];
                ram_req.wdata = ram_rdata & ~victim_bit;
                free_count_next = free_count + 16'd1;
              end
              m_valid_next = 1'b1;
              m_id_next = '0;
              m_status_next = cpba_pkg::STATUS_FREED;
              state_next = ST_IDLE;
            end
          end
          OP_ALLOC: begin
            priority if (|cand) begin
              if (out_free) begin
                ram_req.we = 1'b1;
                ram_req.waddr = cur_word;
                ram_req.wdata = ram_rdata | found_bit;
                free_count_next = free_count - 16'd1;
                last_id_next = found;
                m_valid_next = 1'b1;
                m_id_next = found;
                m_status_next = cpba_pkg::STATUS_OK;
                state_next = ST_IDLE;
              end
            end else if (cur_word != last[14:6]) begin
              cur_word_next = cur_word + 9'd1;
              ram_req.re = 1'b1;
              ram_req.raddr = cur_word + 9'd1;
            end else if (seg_b) begin
              // Wrap around: the rest of the lap runs from the floor up.
              seg_b_next = 1'b0;
              lo_next = cpba_pkg::RESERVED_FLOOR[14:0];
              last_next = seg_b_last;
              cur_word_next = cpba_pkg::RESERVED_FLOOR[14:6];
              ram_req.re = 1'b1;
              ram_req.raddr = cpba_pkg::RESERVED_FLOOR[14:6];
            end else begin
              op_next = OP_FAIL;
            end
          end
          default: begin
            if (out_free) begin
              m_valid_next = 1'b1;
              m_id_next = '0;
              m_status_next = cpba_pkg::STATUS_NO_ID;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      free_count <= cpba_pkg::COUNT_RESET;
      last_id <= '0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      free_count <= free_count_next;
      last_id <= last_id_next;
      m_valid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    cur_word <= cur_word_next;
    victim <= victim_next;
    lo <= lo_next;
    last <= last_next;
    seg_b <= seg_b_next;
    seg_b_last <= seg_b_last_next;
    m_id <= m_id_next;
    m_status <= m_status_next;
  end

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.free_count = free_count;

endmodule
`default_nettype wire
